/* hdl/cbt_pkg.sv */
// Shared constants and types for the cubic Bezier tessellator.
`timescale 1ns / 1ps

package cbt_pkg;

    localparam int COORD_BITS    = 16;
    localparam int SEG_W         = 6;
    localparam int MAX_SEGMENTS  = 63;
    localparam int SEG_RESET     = 20;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [SEG_W-1:0]      t_seg;

    // Sign bit of a coordinate; flipping it maps two's complement to offset binary.
    localparam t_coord CSIGN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam t_coord CMASK = {COORD_BITS{1'b1}};

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    typedef t_vec [3:0] t_ctrl_set;

    // Per-point control that travels down the pipeline.
    typedef struct packed {
        logic valid;
        t_seg idx;
        logic last;
    } t_pt_ctl;

endpackage

/* hdl/cubic_bezier_tessellator_core.sv */
// Top level of the cubic Bezier tessellator.
//
//  Port group        Direction  Handshake            Moves
//  i_p*_x/y/z        in         i_valid / o_stall    one curve item (four control points)
//  o_curve_*, idx    out        o_valid / i_stall    one curve point item
//  i_cfg_wr_*        in         i_cfg_wr_en          segments register
//
// The point sequencer issues one parameter per cycle while the output is not stalled,
// and the next curve is taken in the cycle its last point issues.
// Each issued point passes through the six-stage arithmetic pipeline.
// After reset and after each segments write the serial reciprocal unit runs;
// o_stall stays high meanwhile.
// i_stall on a waiting output item holds the whole pipeline; nothing is dropped.
`timescale 1ns / 1ps

module cubic_bezier_tessellator_core #(
    parameter int FRAC_BITS = cbt_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p0_x,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p0_y,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p0_z,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p1_x,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p1_y,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p1_z,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p2_x,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p2_y,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p2_z,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p3_x,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p3_y,
    input  logic signed [cbt_pkg::COORD_BITS-1:0]  i_p3_z,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [cbt_pkg::COORD_BITS-1:0]  o_curve_x,
    output logic signed [cbt_pkg::COORD_BITS-1:0]  o_curve_y,
    output logic signed [cbt_pkg::COORD_BITS-1:0]  o_curve_z,
    output logic        [cbt_pkg::SEG_W-1:0]       o_point_index,
    output logic                                   o_last_point,
    input  logic                                   i_cfg_wr_en,
    input  logic        [cbt_pkg::SEG_W-1:0]       i_cfg_wr_data
);
    import cbt_pkg::*;

    t_seg                r_seg;
    t_seg                n_seg;
    t_ctrl_set           w_ctrl;
    logic                w_recip_busy;
    logic [FRAC_BITS:0]  w_recip_q;
    t_seg                w_recip_r;
    logic                w_adv;
    t_pt_ctl             w_pt;
    logic [FRAC_BITS:0]  w_b;
    t_ctrl_set           w_gen_ctrl;
    t_coord              w_cx;
    t_coord              w_cy;
    t_coord              w_cz;

    // Zero segments acts as one; clamp to the supported maximum.
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            n_seg = SEG_W'(1);
        end else if (i_cfg_wr_data > SEG_W'(MAX_SEGMENTS)) begin
            n_seg = SEG_W'(MAX_SEGMENTS);
        end else begin
            n_seg = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= SEG_W'(SEG_RESET);
        end else if (i_cfg_wr_en) begin
            r_seg <= n_seg;
        end
    end

    assign w_ctrl[0].x = i_p0_x;
    assign w_ctrl[0].y = i_p0_y;
    assign w_ctrl[0].z = i_p0_z;
    assign w_ctrl[1].x = i_p1_x;
    assign w_ctrl[1].y = i_p1_y;
    assign w_ctrl[1].z = i_p1_z;
    assign w_ctrl[2].x = i_p2_x;
    assign w_ctrl[2].y = i_p2_y;
    assign w_ctrl[2].z = i_p2_z;
    assign w_ctrl[3].x = i_p3_x;
    assign w_ctrl[3].y = i_p3_y;
    assign w_ctrl[3].z = i_p3_z;

    cbt_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_wr_en),
        .i_div   (r_seg),
        .o_busy  (w_recip_busy),
        .o_quot  (w_recip_q),
        .o_rem   (w_recip_r)
    );

    cbt_gen #(.FRAC_BITS(FRAC_BITS)) u_gen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ctrl       (w_ctrl),
        .i_seg        (r_seg),
        .i_recip_busy (w_recip_busy),
        .i_recip_q    (w_recip_q),
        .i_recip_r    (w_recip_r),
        .i_adv        (w_adv),
        .o_pt         (w_pt),
        .o_b          (w_b),
        .o_ctrl       (w_gen_ctrl)
    );

    cbt_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pt          (w_pt),
        .i_b           (w_b),
        .i_ctrl        (w_gen_ctrl),
        .i_stall       (i_stall),
        .o_adv         (w_adv),
        .o_valid       (o_valid),
        .o_curve_x     (w_cx),
        .o_curve_y     (w_cy),
        .o_curve_z     (w_cz),
        .o_point_index (o_point_index),
        .o_last_point  (o_last_point)
    );

    assign o_curve_x = signed'(w_cx);
    assign o_curve_y = signed'(w_cy);
    assign o_curve_z = signed'(w_cz);

endmodule

/* hdl/cbt_recip.sv */
// Bit-serial divider: 2^FRAC_BITS / segments, quotient and remainder.
`timescale 1ns / 1ps

module cbt_recip #(
    parameter int FRAC_BITS = cbt_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  cbt_pkg::t_seg        i_div,
    output logic                 o_busy,
    output logic [FRAC_BITS:0]   o_quot,
    output cbt_pkg::t_seg        o_rem
);
    import cbt_pkg::*;

    localparam int PB = FRAC_BITS + 1;
    localparam int CW = $clog2(PB + 1);

    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    t_seg           r_rem;
    t_seg           n_rem;
    logic [PB-1:0]  r_quot;
    logic [SEG_W:0] m_shift;
    logic [SEG_W:0] m_sub;
    logic           m_ge;

    // Dividend is a one followed by FRAC_BITS zeros, fed MSB first.
    always_comb begin
        m_shift = {r_rem, (r_cnt == CW'(PB))};
        m_ge    = (m_shift >= {1'b0, i_div});
        m_sub   = m_shift - {1'b0, i_div};
        n_rem   = m_ge ? m_sub[SEG_W-1:0] : m_shift[SEG_W-1:0];
        n_cnt   = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CW'(PB);
            r_rem <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(PB);
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_cnt <= n_cnt;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt != '0 && !i_start) begin
            r_quot <= {r_quot[PB-2:0], m_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

/* hdl/cbt_gen.sv */
// Point sequencer: holds one curve and issues its parameter values one per cycle while i_adv is high.
`timescale 1ns / 1ps

module cbt_gen #(
    parameter int FRAC_BITS = cbt_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cbt_pkg::t_ctrl_set   i_ctrl,
    input  cbt_pkg::t_seg        i_seg,
    input  logic                 i_recip_busy,
    input  logic [FRAC_BITS:0]   i_recip_q,
    input  cbt_pkg::t_seg        i_recip_r,
    input  logic                 i_adv,
    output cbt_pkg::t_pt_ctl     o_pt,
    output logic [FRAC_BITS:0]   o_b,
    output cbt_pkg::t_ctrl_set   o_ctrl
);
    import cbt_pkg::*;

    localparam int PB = FRAC_BITS + 1;
    localparam logic [PB-1:0] ONE = PB'(1) << FRAC_BITS;

    logic           r_busy;
    t_seg           r_idx;
    logic [PB-1:0]  r_q;
    t_seg           r_rem;
    t_ctrl_set      r_ctrl;

    logic           m_issue;
    logic           m_last;
    logic           m_accept;
    logic [SEG_W:0] m_rsum;
    logic [SEG_W:0] m_rsub;
    logic           m_carry;
    t_seg           n_rem;
    logic [PB-1:0]  n_q;

    always_comb begin
        m_issue  = r_busy && i_adv;
        m_last   = (r_idx == i_seg);
        o_stall  = i_recip_busy || (r_busy && !(m_issue && m_last));
        m_accept = i_valid && !o_stall;
        // Step b by 2^F/seg exactly: add quotient, carry the remainder.
        m_rsum   = {1'b0, r_rem} + {1'b0, i_recip_r};
        m_carry  = (m_rsum >= {1'b0, i_seg});
        m_rsub   = m_rsum - {1'b0, i_seg};
        n_rem    = m_carry ? m_rsub[SEG_W-1:0] : m_rsum[SEG_W-1:0];
        n_q      = r_q + i_recip_q + PB'(m_carry);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_q    <= '0;
            r_rem  <= '0;
        end else if (m_accept) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_q    <= '0;
            r_rem  <= '0;
        end else if (m_issue) begin
            if (m_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + SEG_W'(1);
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    // Store control points in offset binary.
    always_ff @(posedge i_clk) begin
        if (m_accept) begin
            for (int k = 0; k < 4; k++) begin
                r_ctrl[k].x <= i_ctrl[k].x ^ CSIGN;
                r_ctrl[k].y <= i_ctrl[k].y ^ CSIGN;
                r_ctrl[k].z <= i_ctrl[k].z ^ CSIGN;
            end
        end
    end

    always_comb begin
        o_pt.valid = m_issue;
        o_pt.idx   = r_idx;
        o_pt.last  = m_last;
        o_b        = r_q;
        o_ctrl     = r_ctrl;
    end

    a_no_issue_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_recip_busy)
        else $error("curve in progress while reciprocal unit busy");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= i_seg))
        else $error("point index ran past segment count");

    a_last_is_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_issue && m_last) |-> (r_q == ONE))
        else $error("parameter not exactly one on last point");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_issue && m_last && !m_accept) |=> !r_busy)
        else $error("sequencer still busy after last point");

endmodule

/* hdl/cbt_pipe.sv */
// Arithmetic pipeline: Bernstein weights, weighted sums, rounding, saturation.
`timescale 1ns / 1ps

module cbt_pipe #(
    parameter int FRAC_BITS = cbt_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbt_pkg::t_pt_ctl     i_pt,
    input  logic [FRAC_BITS:0]   i_b,
    input  cbt_pkg::t_ctrl_set   i_ctrl,
    input  logic                 i_stall,
    output logic                 o_adv,
    output logic                 o_valid,
    output cbt_pkg::t_coord      o_curve_x,
    output cbt_pkg::t_coord      o_curve_y,
    output cbt_pkg::t_coord      o_curve_z,
    output cbt_pkg::t_seg        o_point_index,
    output logic                 o_last_point
);
    import cbt_pkg::*;

    localparam int PB  = FRAC_BITS + 1;
    localparam int B3W = PB + 2;
    localparam int MW  = 3 * PB + 2;
    localparam int WW  = 3 * FRAC_BITS + 1;
    localparam int PW  = WW + COORD_BITS;
    localparam int S1W = PW + 1;
    localparam int SW  = PW + 2;
    localparam int RW  = SW - 3 * FRAC_BITS;
    localparam logic [PB-1:0] ONE = PB'(1) << FRAC_BITS;
    localparam logic [SW-1:0] RND = SW'(1) << (3 * FRAC_BITS - 1);

    // stage 1: a, b, 3b
    t_pt_ctl          r1_pt;
    logic [PB-1:0]    r1_a;
    logic [PB-1:0]    r1_b;
    logic [B3W-1:0]   r1_b3;
    t_ctrl_set        r1_c;
    // stage 2: squares
    t_pt_ctl          r2_pt;
    logic [2*PB-1:0]  r2_aa;
    logic [2*PB-1:0]  r2_ab;
    logic [2*PB-1:0]  r2_bb;
    logic [PB-1:0]    r2_a;
    logic [PB-1:0]    r2_b;
    logic [B3W-1:0]   r2_b3;
    t_ctrl_set        r2_c;
    // stage 3: weights
    t_pt_ctl          r3_pt;
    logic [WW-1:0]    r3_w [4];
    t_ctrl_set        r3_c;
    // stage 4: weighted control values
    t_pt_ctl          r4_pt;
    logic [PW-1:0]    r4_p [3][4];
    // stage 5: pair sums
    t_pt_ctl          r5_pt;
    logic [S1W-1:0]   r5_s01 [3];
    logic [S1W-1:0]   r5_s23 [3];
    // stage 6: output
    t_pt_ctl          r6_pt;
    t_coord           r6_o [3];

    logic [WW-1:0]    m_w [4];
    t_coord           m_c [4][3];
    logic [SW-1:0]    m_tot [3];
    logic [RW-1:0]    m_r [3];
    t_coord           m_o [3];

    // Hold every stage while the output item waits.
    assign o_adv = !(r6_pt.valid && i_stall);

    always_comb begin
        m_w[0] = WW'(MW'(r2_aa) * MW'(r2_a));
        m_w[1] = WW'(MW'(r2_aa) * MW'(r2_b3));
        m_w[2] = WW'(MW'(r2_ab) * MW'(r2_b3));
        m_w[3] = WW'(MW'(r2_bb) * MW'(r2_b));
        for (int k = 0; k < 4; k++) begin
            m_c[k][0] = r3_c[k].x;
            m_c[k][1] = r3_c[k].y;
            m_c[k][2] = r3_c[k].z;
        end
        for (int d = 0; d < 3; d++) begin
            m_tot[d] = SW'(r5_s01[d]) + SW'(r5_s23[d]) + RND;
            m_r[d]   = m_tot[d][SW-1:3*FRAC_BITS];
            m_o[d]   = (m_r[d] > RW'(CMASK)) ? CMASK : m_r[d][COORD_BITS-1:0];
            m_o[d]   = m_o[d] ^ CSIGN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_pt <= '0;
            r2_pt <= '0;
            r3_pt <= '0;
            r4_pt <= '0;
            r5_pt <= '0;
            r6_pt <= '0;
        end else if (o_adv) begin
            r1_pt <= i_pt;
            r2_pt <= r1_pt;
            r3_pt <= r2_pt;
            r4_pt <= r3_pt;
            r5_pt <= r4_pt;
            r6_pt <= r5_pt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r1_a  <= ONE - i_b;
            r1_b  <= i_b;
            r1_b3 <= B3W'(i_b) + (B3W'(i_b) << 1);
            r1_c  <= i_ctrl;

            r2_aa <= (2*PB)'(r1_a) * (2*PB)'(r1_a);
            r2_ab <= (2*PB)'(r1_a) * (2*PB)'(r1_b);
            r2_bb <= (2*PB)'(r1_b) * (2*PB)'(r1_b);
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_b3 <= r1_b3;
            r2_c  <= r1_c;

            for (int k = 0; k < 4; k++) begin
                r3_w[k] <= m_w[k];
            end
            r3_c <= r2_c;

            for (int d = 0; d < 3; d++) begin
                for (int k = 0; k < 4; k++) begin
                    r4_p[d][k] <= PW'(r3_w[k]) * PW'(m_c[k][d]);
                end
                r5_s01[d] <= S1W'(r4_p[d][0]) + S1W'(r4_p[d][1]);
                r5_s23[d] <= S1W'(r4_p[d][2]) + S1W'(r4_p[d][3]);
                r6_o[d]   <= m_o[d];
            end
        end
    end

    assign o_valid       = r6_pt.valid;
    assign o_curve_x     = r6_o[0];
    assign o_curve_y     = r6_o[1];
    assign o_curve_z     = r6_o[2];
    assign o_point_index = r6_pt.idx;
    assign o_last_point  = r6_pt.last;

endmodule

/* sim/tb_cubic_bezier_tessellator_core.sv */
// Self-checking testbench for the cubic Bezier tessellator core.
`timescale 1ns / 1ps

module tb_cubic_bezier_tessellator_core;
    import cbt_pkg::*;

    localparam int         FB          = FRAC_BITS_DEF;
    localparam bit [127:0] ROUND_HALF  = 128'd1 << (3 * FB - 1);
    localparam int         SETTLE_CYC  = 12;
    localparam int         CYCLE_LIMIT = 600000;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        t_seg   idx;
        logic   last;
    } t_curve_pt;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       i_stall       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    t_seg       i_cfg_wr_data = '0;
    t_ctrl_set  drv_curve     = '0;
    logic       o_stall;
    logic       o_valid;
    logic signed [COORD_BITS-1:0] o_curve_x, o_curve_y, o_curve_z;
    logic       [SEG_W-1:0]       o_point_index;
    logic                         o_last_point;

    t_ctrl_set  curve_queue [$];
    t_curve_pt  point_queue [$];
    t_seg       seg_cfg       = t_seg'(SEG_RESET);
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         queued_cnt    = 0;
    int         accepted_cnt  = 0;
    int         mismatch_cnt  = 0;
    int         cycle_cnt     = 0;
    t_curve_pt  got_pt, want_pt;

    cubic_bezier_tessellator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_p0_x        (drv_curve[0].x),
        .i_p0_y        (drv_curve[0].y),
        .i_p0_z        (drv_curve[0].z),
        .i_p1_x        (drv_curve[1].x),
        .i_p1_y        (drv_curve[1].y),
        .i_p1_z        (drv_curve[1].z),
        .i_p2_x        (drv_curve[2].x),
        .i_p2_y        (drv_curve[2].y),
        .i_p2_z        (drv_curve[2].z),
        .i_p3_x        (drv_curve[3].x),
        .i_p3_y        (drv_curve[3].y),
        .i_p3_z        (drv_curve[3].z),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_curve_x     (o_curve_x),
        .o_curve_y     (o_curve_y),
        .o_curve_z     (o_curve_z),
        .o_point_index (o_point_index),
        .o_last_point  (o_last_point),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Exact Bernstein sum at scale 2^(3*FB), coordinates in offset binary.
    function automatic void predict_points(input t_ctrl_set cs);
        int unsigned nseg;
        bit [127:0]  pb, pa, acc, ctl;
        bit [127:0]  wt [4];
        t_coord      res [3];
        t_vec        v;
        t_curve_pt   pt;
        nseg = (seg_cfg == 0) ? 1 : 32'(seg_cfg);
        for (int i = 0; i <= nseg; i++) begin
            pb = 128'((i << FB) / nseg);
            pa = (128'd1 << FB) - pb;
            wt[0] = pa * pa * pa;
            wt[1] = 3 * pa * pa * pb;
            wt[2] = 3 * pa * pb * pb;
            wt[3] = pb * pb * pb;
            for (int d = 0; d < 3; d++) begin
                acc = ROUND_HALF;
                for (int k = 0; k < 4; k++) begin
                    v   = cs[k];
                    ctl = 128'((d == 0) ? v.x : ((d == 1) ? v.y : v.z));
                    ctl = ctl ^ 128'(CSIGN);
                    acc = acc + wt[k] * ctl;
                end
                acc = acc >> (3 * FB);
                if (acc > 128'(CMASK))
                    acc = 128'(CMASK);
                res[d] = acc[COORD_BITS-1:0] ^ CSIGN;
            end
            pt.x    = res[0];
            pt.y    = res[1];
            pt.z    = res[2];
            pt.idx  = t_seg'(i);
            pt.last = (i == nseg);
            point_queue.push_back(pt);
        end
    endfunction

    function automatic t_vec vec(input int x, input int y, input int z);
        t_vec v;
        v.x = t_coord'(x);
        v.y = t_coord'(y);
        v.z = t_coord'(z);
        return v;
    endfunction

    // Favor the extremes and small values, otherwise full range.
    function automatic t_coord rand_coord();
        case ($urandom_range(9))
            0: return CSIGN;
            1: return ~CSIGN;
            2: return '0;
            3: return t_coord'($urandom_range(16) - 8);
            default: return t_coord'($urandom());
        endcase
    endfunction

    task automatic push_curve(input t_vec p0, input t_vec p1, input t_vec p2, input t_vec p3);
        t_ctrl_set cs;
        cs[0] = p0;
        cs[1] = p1;
        cs[2] = p2;
        cs[3] = p3;
        curve_queue.push_back(cs);
        queued_cnt++;
    endtask

    task automatic push_random(input int count);
        t_vec p [4];
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < 4; k++) begin
                p[k].x = rand_coord();
                p[k].y = rand_coord();
                p[k].z = rand_coord();
            end
            push_curve(p[0], p[1], p[2], p[3]);
        end
    endtask

    // Hold until every queued item is taken and all its points are back.
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || point_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_segments(input t_seg value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        seg_cfg = value;
    endtask

    task automatic run_phase(input t_seg value, input int count, input int s_pct,
                             input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_segments(value);
        push_random(count / 2);
        wait_drained();
        push_random(count - count / 2);
        wait_drained();
    endtask

    task automatic report_bad(input string what, input t_curve_pt want, input t_curve_pt got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $write("%s: want x=%0d y=%0d z=%0d idx=%0d last=%0b",
                   what, $signed(want.x), $signed(want.y), $signed(want.z), want.idx,
                   want.last);
            $display(", got x=%0d y=%0d z=%0d idx=%0d last=%0b",
                     $signed(got.x), $signed(got.y), $signed(got.z), got.idx, got.last);
        end
    endtask

    // Driver: present the next curve item, predict its points when it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_points(drv_curve);
                accepted_cnt++;
            end
            if (!i_valid || !o_stall) begin
                if (curve_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_curve <= curve_queue.pop_front();
                    i_valid   <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each point item against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got_pt.x    = o_curve_x;
                got_pt.y    = o_curve_y;
                got_pt.z    = o_curve_z;
                got_pt.idx  = o_point_index;
                got_pt.last = o_last_point;
                if (point_queue.size() == 0) begin
                    report_bad("unexpected point", '0, got_pt);
                end else begin
                    want_pt = point_queue.pop_front();
                    if (got_pt.x !== want_pt.x || got_pt.y !== want_pt.y ||
                        got_pt.z !== want_pt.z || got_pt.idx !== want_pt.idx ||
                        got_pt.last !== want_pt.last)
                        report_bad("point mismatch", want_pt, got_pt);
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        send_idle_pct = 23;
        recv_idle_pct = 54;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items at the reset segment count; half-way point is exact there.
        push_curve(vec(0, 0, 0), vec(0, 0, 0), vec(0, 0, 0), vec(0, 0, 0));
        push_curve(vec(32767, 32767, 32767), vec(32767, 32767, 32767),
                   vec(32767, 32767, 32767), vec(32767, 32767, 32767));
        push_curve(vec(-32768, -32768, -32768), vec(-32768, -32768, -32768),
                   vec(-32768, -32768, -32768), vec(-32768, -32768, -32768));
        push_curve(vec(-32768, 32767, 0), vec(-32768, 32767, -32768),
                   vec(32767, -32768, 32767), vec(32767, -32768, 0));
        push_curve(vec(32767, -32768, 32767), vec(-32768, 32767, -32768),
                   vec(32767, -32768, 32767), vec(-32768, 32767, -32768));
        push_curve(vec(-32768, -32768, -32768), vec(32767, 32767, 32767),
                   vec(32767, 32767, 32767), vec(-32768, -32768, -32768));
        push_curve(vec(32767, 32767, 32767), vec(-32768, -32768, -32768),
                   vec(-32768, -32768, -32768), vec(32767, 32767, 32767));
        // Rounding half up: +0.5 goes to 1, -0.5 goes to 0.
        push_curve(vec(4, -4, 1), vec(0, 0, 0), vec(0, 0, 0), vec(0, 0, 0));
        push_curve(vec(0, 0, 0), vec(0, 0, 0), vec(0, 0, 0), vec(4, -4, -1));
        push_curve(vec(1, -1, 2), vec(-1, 1, -2), vec(1, -1, 2), vec(-1, 1, -2));
        push_curve(vec(-1, 1, 0), vec(-1, 1, 0), vec(1, -1, 0), vec(1, -1, 0));
        push_curve(vec(-1234, 5678, -32768), vec(-1234, 5678, -32768),
                   vec(-1234, 5678, -32768), vec(-1234, 5678, -32768));
        push_curve(vec(16'h5555, 16'hAAAA, 16'h5555), vec(16'hAAAA, 16'h5555, 16'hAAAA),
                   vec(16'h5555, 16'hAAAA, 16'h5555), vec(16'hAAAA, 16'h5555, 16'hAAAA));
        push_curve(vec(-32768, 32767, -32768), vec(-10923, 10922, -10923),
                   vec(10922, -10923, 10922), vec(32767, -32768, 32767));
        push_curve(vec(12345, -23456, 32767), vec(-7, 30000, -30000),
                   vec(29999, 3, -12345), vec(-32768, 1, 7));
        push_curve(vec(0, 32767, -32768), vec(32767, 0, 0), vec(0, -32768, 32767),
                   vec(-32768, 0, 0));
        wait_drained();

        // Segment count zero behaves as one.
        run_phase(t_seg'(0), 40, 23, 54);
        run_phase(t_seg'(1), 40, 23, 54);
        run_phase(t_seg'(MAX_SEGMENTS), 30, 23, 54);
        run_phase(t_seg'(2), 50, 23, 54);
        run_phase(t_seg'(7), 60, 54, 23);
        run_phase(t_seg'(20), 60, 54, 23);
        run_phase(t_seg'(33), 50, 54, 23);
        run_phase(t_seg'(62), 30, 0, 0);
        run_phase(t_seg'(3), 60, 0, 0);
        run_phase(t_seg'(45), 50, 0, 0);

        if (mismatch_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/cbt_pkg.sv
hdl/cbt_recip.sv
hdl/cbt_gen.sv
hdl/cbt_pipe.sv
hdl/cubic_bezier_tessellator_core.sv
sim/tb_cubic_bezier_tessellator_core.sv
